### rtl/core/sha1md_pkg.sv
`default_nettype none

package sha1md_pkg;

	localparam int JOBQ_DEPTH = 2;

	typedef logic [15:0][31:0] block_t;
	typedef logic [4:0][31:0] chain_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word0;
		logic [31:0] digest_word1;
		logic [31:0] digest_word2;
		logic [31:0] digest_word3;
		logic [31:0] digest_word4;
	} digest_t;

	typedef struct packed {
		block_t     words;
		logic [5:0] nbytes;
		logic       full;
		logic       last;
	} job_t;

	localparam chain_t H_INIT = {
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	localparam logic [31:0] K_CH     = 32'h5a827999;
	localparam logic [31:0] K_PAR_LO = 32'h6ed9eba1;
	localparam logic [31:0] K_MAJ    = 32'h8f1bbcdc;
	localparam logic [31:0] K_PAR_HI = 32'hca62c1d6;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [5:0]  LEN_ROOM = 6'd56;

	function automatic logic [31:0] rotl1(input logic [31:0] v);
		return {v[30:0], v[31]};
	endfunction

	function automatic block_t pad_block(input block_t blk, input logic [5:0] nbytes);
		block_t     r;
		logic [5:0] idx;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			for (int j = 0; j < 4; j++) begin
				idx = 6'(4 * i + j);
				if (idx < nbytes)
					r[i][8*(3-j) +: 8] = blk[i][8*(3-j) +: 8];
				else if (idx == nbytes)
					r[i][8*(3-j) +: 8] = PAD_BYTE;
				else
					r[i][8*(3-j) +: 8] = 8'h00;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/sha1md_front.sv
`default_nettype none

module sha1md_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire sha1md_pkg::item_t item,
	output logic                   job_push,
	output sha1md_pkg::job_t       job,
	input  wire logic              job_full
);
	import sha1md_pkg::*;

	block_t     blk_q;
	block_t     blk_d;
	logic [5:0] cnt_q;
	logic [5:0] cnt_inc;
	logic       accept;
	logic       blk_full;

	assign full     = job_full;
	assign accept   = push && !job_full;
	assign cnt_inc  = cnt_q + 6'd1;
	assign blk_full = item.byte_present && (cnt_q == 6'd63);

	always_comb begin
		blk_d = blk_q;
		if (item.byte_present)
			blk_d[cnt_q[5:2]][{~cnt_q[1:0], 3'b000} +: 8] = item.data_byte;
	end

	assign job_push   = accept && (blk_full || item.message_end);
	assign job.words  = blk_d;
	assign job.nbytes = item.byte_present ? cnt_inc : cnt_q;
	assign job.full   = blk_full;
	assign job.last   = item.message_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (item.message_end)
				cnt_q <= '0;
			else if (item.byte_present)
				cnt_q <= cnt_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			blk_q <= blk_d;
	end

endmodule

`default_nettype wire

### rtl/core/sha1md_jobq.sv
`default_nettype none

module sha1md_jobq #(
	parameter int DEPTH = sha1md_pkg::JOBQ_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire sha1md_pkg::job_t wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output sha1md_pkg::job_t      rd_data,
	output logic                  empty
);
	import sha1md_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

### rtl/core/sha1md_back.sv
`default_nettype none

module sha1md_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_valid,
	input  wire sha1md_pkg::job_t job,
	output logic                  job_pop,
	input  wire logic             pop,
	output logic                  empty,
	output sha1md_pkg::digest_t   digest
);
	import sha1md_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PAD,
		S_ROUND,
		S_ADD
	} state_t;

	state_t      state_q;
	block_t      w_q;
	chain_t      chain_q;
	chain_t      sum;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [54:0] blocks_q;
	logic [6:0]  t_q;
	logic [5:0]  p_q;
	logic [63:0] len_q;
	logic        last_q;
	logic        final_q;
	logic        second_q;
	logic        out_valid_q;
	digest_t     out_q;

	logic [63:0] len;
	block_t      padded;
	block_t      padded_len;
	block_t      tail_blk;
	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] tmp;
	logic [31:0] w_new;
	logic        out_free;
	logic        emit;

	assign empty    = !out_valid_q;
	assign digest   = out_q;
	assign out_free = !out_valid_q || pop;
	assign job_pop  = (state_q == S_IDLE) && job_valid;
	assign emit     = (state_q == S_ADD) && final_q && !second_q && out_free;

	assign len   = {blocks_q, p_q, 3'b000};
	assign w_new = rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);

	always_comb begin
		padded         = pad_block(w_q, p_q);
		padded_len     = padded;
		padded_len[14] = len[63:32];
		padded_len[15] = len[31:0];
		tail_blk       = '0;
		tail_blk[14]   = len_q[63:32];
		tail_blk[15]   = len_q[31:0];
	end

	always_comb begin
		if (t_q inside {[7'd0:7'd19]}) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K_CH;
		end else if (t_q inside {[7'd20:7'd39]}) begin
			f = b_q ^ c_q ^ d_q;
			k = K_PAR_LO;
		end else if (t_q inside {[7'd40:7'd59]}) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K_MAJ;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_PAR_HI;
		end
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
	end

	assign sum[0] = chain_q[0] + a_q;
	assign sum[1] = chain_q[1] + b_q;
	assign sum[2] = chain_q[2] + c_q;
	assign sum[3] = chain_q[3] + d_q;
	assign sum[4] = chain_q[4] + e_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			w_q         <= '0;
			chain_q     <= H_INIT;
			a_q         <= '0;
			b_q         <= '0;
			c_q         <= '0;
			d_q         <= '0;
			e_q         <= '0;
			blocks_q    <= '0;
			t_q         <= '0;
			p_q         <= '0;
			len_q       <= '0;
			last_q      <= 1'b0;
			final_q     <= 1'b0;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						w_q      <= job.words;
						p_q      <= job.nbytes;
						last_q   <= job.last;
						final_q  <= 1'b0;
						second_q <= 1'b0;
						if (job.full) begin
							{a_q, b_q, c_q, d_q, e_q} <=
								{chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
							t_q     <= '0;
							state_q <= S_ROUND;
						end else begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					last_q <= 1'b0;
					if (p_q >= LEN_ROOM) begin
						w_q      <= padded;
						len_q    <= len;
						second_q <= 1'b1;
					end else begin
						w_q     <= padded_len;
						final_q <= 1'b1;
					end
					{a_q, b_q, c_q, d_q, e_q} <=
						{chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
					t_q     <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					for (int i = 0; i < 15; i++)
						w_q[i] <= w_q[i+1];
					w_q[15] <= w_new;
					e_q     <= d_q;
					d_q     <= c_q;
					c_q     <= {b_q[1:0], b_q[31:2]};
					b_q     <= a_q;
					a_q     <= tmp;
					t_q     <= t_q + 7'd1;
					if (t_q == 7'd79)
						state_q <= S_ADD;
				end
				S_ADD: begin
					if (!final_q || out_free) begin
						if (second_q) begin
							chain_q  <= sum;
							blocks_q <= blocks_q + 55'd1;
							w_q      <= tail_blk;
							second_q <= 1'b0;
							final_q  <= 1'b1;
							{a_q, b_q, c_q, d_q, e_q} <=
								{sum[0], sum[1], sum[2], sum[3], sum[4]};
							t_q      <= '0;
							state_q  <= S_ROUND;
						end else if (final_q) begin
							out_q    <= {sum[0], sum[1], sum[2], sum[3], sum[4]};
							chain_q  <= H_INIT;
							blocks_q <= '0;
							final_q  <= 1'b0;
							state_q  <= S_IDLE;
						end else begin
							chain_q  <= sum;
							blocks_q <= blocks_q + 55'd1;
							if (last_q) begin
								p_q     <= '0;
								state_q <= S_PAD;
							end else begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/sha1_message_digest.sv
// Channel  Signals                 Transfer when     Payload
// -------  ----------------------  ----------------  -----------------------------------
// input    push, full, item        push && !full     data_byte, byte_present, message_end
// result   empty, pop, digest      pop && !empty     digest_word0 .. digest_word4
//
// Bytes are taken one per cycle while the job queue has room; a full 64-byte block
// or a message end becomes one job for the compression engine.
// In the engine each loaded block takes a load, 80 rounds at one per cycle and an add;
// a message end adds one padding step, and each padding block beyond the loaded one
// adds 80 rounds and an add.
// Reset returns the chaining words, byte count and job queue to their start values.
// A held result stalls the engine only at its final add; the front stalls on a full queue.
`default_nettype none

module sha1_message_digest #(
	parameter int QUEUE_DEPTH = sha1md_pkg::JOBQ_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire sha1md_pkg::item_t   item,
	output logic                     empty,
	input  wire logic                pop,
	output sha1md_pkg::digest_t      digest
);
	import sha1md_pkg::*;

	job_t front_job;
	job_t back_job;
	logic front_push;
	logic q_full;
	logic q_empty;
	logic back_pop;

	sha1md_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.job_push (front_push),
		.job      (front_job),
		.job_full (q_full)
	);

	sha1md_jobq #(
		.DEPTH (QUEUE_DEPTH)
	) u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_push),
		.wr_data (front_job),
		.full    (q_full),
		.rd_en   (back_pop),
		.rd_data (back_job),
		.empty   (q_empty)
	);

	sha1md_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!q_empty),
		.job       (back_job),
		.job_pop   (back_pop),
		.pop       (pop),
		.empty     (empty),
		.digest    (digest)
	);

endmodule

`default_nettype wire

### rtl/core/sha1md_check.sv
`default_nettype none

module sha1md_check (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                push,
	input wire logic                full,
	input wire sha1md_pkg::item_t   item,
	input wire logic                empty,
	input wire logic                pop,
	input wire sha1md_pkg::digest_t digest
);
	logic [2:0] pending_q;
	logic       end_in;
	logic       res_out;

	assign end_in  = push && !full && item.message_end;
	assign res_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (end_in && !res_out)
			pending_q <= pending_q + 3'd1;
		else if (res_out && !end_in)
			pending_q <= pending_q - 3'd1;
	end

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(digest))
		else $error("result changed while waiting");

	ap_owed: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pending_q != 3'd0)
		else $error("result without a finished message");

	ap_latency: assert property (@(posedge clk) disable iff (!arst_n)
		end_in && pending_q == 3'd0 |=> empty)
		else $error("digest appeared too early");

	ap_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_out && !end_in && pending_q == 3'd1 |=> empty)
		else $error("extra result after the last owed one");

endmodule

bind sha1_message_digest sha1md_check u_check (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.item   (item),
	.empty  (empty),
	.pop    (pop),
	.digest (digest)
);

`default_nettype wire

### bench/sha1_message_digest_tb.sv
`default_nettype none

module sha1_message_digest_tb;
	import sha1md_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 540;
	localparam int MSGS_PER_PHASE = 8;
	localparam int DRAIN_CYCLES = 400;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hc3d2e1f0;

	localparam digest_t EMPTY_DIGEST = {
		32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890, 32'hafd80709
	};
	localparam digest_t ABC_DIGEST = {
		32'ha9993e36, 32'h4706816a, 32'hba3e2571, 32'h7850c26c, 32'h9cd0d89d
	};

	localparam int EDGE_LENS [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

	typedef struct packed {
		item_t   it;
		logic    known;
		digest_t want;
	} row_t;

	localparam int N_ROWS = 17;
	localparam row_t DIRECTED_ROWS [N_ROWS] = '{
		'{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
		'{'{8'h61, 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
		'{'{8'h62, 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_DIGEST},
		'{'{8'h61, 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'h62, 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'h63, 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'haa, 1'b0, 1'b1}, 1'b1, ABC_DIGEST},
		'{'{8'h00, 1'b1, 1'b1}, 1'b0, '0},
		'{'{8'hff, 1'b1, 1'b1}, 1'b0, '0},
		'{'{8'h55, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
		'{'{8'hff, 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'h80, 1'b0, 1'b1}, 1'b0, '0},
		'{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
		'{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST}
	};

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	digest_t digest;

	logic [31:0] chain [5];
	logic [31:0] sched [16];
	logic [5:0]  fill;
	logic [54:0] nblocks;

	digest_t pending_digests [$];
	int      fails;
	int      transfers_in;
	int      digests_seen;
	int      messages_sent;
	int      send_idle_pct;
	int      recv_idle_pct;

	sha1_message_digest u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.digest (digest)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] rol(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void sha1_restart();
		chain[0] = IV0;
		chain[1] = IV1;
		chain[2] = IV2;
		chain[3] = IV3;
		chain[4] = IV4;
		for (int i = 0; i < 16; i++)
			sched[i] = '0;
		fill = '0;
		nblocks = '0;
	endfunction

	function automatic void sha1_put(input int idx, input logic [7:0] v);
		sched[(idx >> 2) & 15][8 * (3 - (idx & 3)) +: 8] = v;
	endfunction

	function automatic void sha1_compress();
		logic [31:0] a, b, c, d, e, f, k, t;
		int          s;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int r = 0; r < 80; r++) begin
			s = r & 15;
			if (r >= 16)
				sched[s] = rol(sched[(s + 13) & 15] ^ sched[(s + 8) & 15] ^
					sched[(s + 2) & 15] ^ sched[s], 1);
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_CH;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_PAR_LO;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = K_PAR_HI;
			end
			t = rol(a, 5) + f + e + k + sched[s];
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = t;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
		nblocks++;
	endfunction

	function automatic bit sha1_absorb(input item_t it, output digest_t dg);
		logic [63:0] bitlen;
		int          p;
		dg = '0;
		if (it.byte_present) begin
			sha1_put(fill, it.data_byte);
			fill++;
			if (fill == 0)
				sha1_compress();
		end
		if (!it.message_end)
			return 1'b0;
		bitlen = {nblocks, fill, 3'b000};
		p = fill;
		sha1_put(p, 8'h80);
		for (int i = p + 1; i < 64; i++)
			sha1_put(i, 8'h00);
		if (p >= 56) begin
			sha1_compress();
			for (int i = 0; i < 14; i++)
				sched[i] = '0;
		end
		sched[14] = bitlen[63:32];
		sched[15] = bitlen[31:0];
		sha1_compress();
		dg = {chain[0], chain[1], chain[2], chain[3], chain[4]};
		sha1_restart();
		return 1'b1;
	endfunction

	// enter and leave at a falling edge; push is left high
	task automatic send_item(input item_t it, input logic known, input digest_t want);
		digest_t dg;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (it.byte_present || it.message_end)
			transfers_in++;
		if (sha1_absorb(it, dg)) begin
			pending_digests.push_back(known ? want : dg);
			messages_sent++;
		end
		@(negedge clk);
	endtask

	task automatic send_message();
		int    len;
		int    pick;
		bit    end_with_byte;
		item_t it;
		pick = $urandom_range(19);
		if (pick < 10)
			len = $urandom_range(12);
		else if (pick < 15)
			len = EDGE_LENS[$urandom_range(8)];
		else if (pick < 18)
			len = $urandom_range(130);
		else if (pick == 18)
			len = $urandom_range(300, 129);
		else
			len = 0;
		end_with_byte = (len > 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(15) == 0) begin
				it = '{data_byte: 8'($urandom), byte_present: 1'b0, message_end: 1'b0};
				send_item(it, 1'b0, '0);
			end
			it.data_byte = 8'($urandom);
			it.byte_present = 1'b1;
			it.message_end = end_with_byte && (i == len - 1);
			send_item(it, 1'b0, '0);
		end
		if (!end_with_byte) begin
			it = '{data_byte: 8'($urandom), byte_present: 1'b0, message_end: 1'b1};
			send_item(it, 1'b0, '0);
		end
	endtask

	// hold the sender until every digest in flight has been taken
	task automatic drain_pause();
		push <= 1'b0;
		@(negedge clk);
		while (pending_digests.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_phase(input int s_idle, input int r_idle);
		int items0;
		int msgs0;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		items0 = transfers_in;
		msgs0 = messages_sent;
		while (transfers_in - items0 < ITEMS_PER_PHASE || messages_sent - msgs0 < MSGS_PER_PHASE) begin
			send_message();
			if ($urandom_range(24) == 0)
				drain_pause();
		end
		drain_pause();
	endtask

	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				digests_seen++;
				if (pending_digests.size() == 0) begin
					$error("digest transfer with nothing expected: %h", digest);
					fails++;
				end else begin
					digest_t want;
					want = pending_digests.pop_front();
					for (int i = 0; i < 5; i++) begin
						if (digest[159 - 32 * i -: 32] !== want[159 - 32 * i -: 32]) begin
							$error("digest_word%0d: expected %h, got %h", i,
								want[159 - 32 * i -: 32], digest[159 - 32 * i -: 32]);
							fails++;
						end
					end
				end
			end
			@(negedge clk);
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stall = 0;
			else
				stall++;
		end
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		fails = 0;
		transfers_in = 0;
		digests_seen = 0;
		messages_sent = 0;
		send_idle_pct = 31;
		recv_idle_pct = 78;
		sha1_restart();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_item(DIRECTED_ROWS[i].it, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
		drain_pause();

		random_phase(31, 78);
		random_phase(78, 31);
		random_phase(0, 0);

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d byte and end transfers in, %0d digests out, over empty, short,",
			transfers_in, digests_seen);
		$display("padding-boundary and multi-block messages under three flow-control mixes");
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
